/* rtl/core/chld_pkg.sv */
package chld_pkg;

  localparam int BINS        = 16;
  localparam int CHANNELS    = 3;
  localparam int ENTRIES     = CHANNELS * BINS;
  localparam int BIN_BITS    = $clog2(BINS);
  localparam int SAMPLE_W    = 8;
  localparam int PROD_W      = SAMPLE_W + 9;
  localparam int DIFF_W      = 26;
  localparam int REG_W       = 13;
  localparam int CFG_INDEX_W = 4;
  localparam int SWEEP_W     = $clog2(ENTRIES);
  localparam int SUM_W       = DIFF_W + $clog2(ENTRIES);
  localparam int AREA_W      = 2 * REG_W;
  localparam int DIVISOR_W   = AREA_W + 3;
  localparam int SCORE_W     = 17;
  localparam int DIV_STEPS   = SCORE_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  typedef logic signed [DIFF_W-1:0] diff_t;

  localparam diff_t DIFF_MAX = {1'b0, {(DIFF_W-1){1'b1}}};
  localparam diff_t DIFF_MIN = {1'b1, {(DIFF_W-1){1'b0}}};

  localparam logic [SCORE_W-1:0] SCORE_ONE = {1'b1, {(SCORE_W-1){1'b0}}};

  localparam logic [CFG_INDEX_W-1:0] REG_A_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_A_HEIGHT = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_B_WIDTH  = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_B_HEIGHT = CFG_INDEX_W'(3);

  typedef struct packed {
    logic [SAMPLE_W-1:0] a_red;
    logic [SAMPLE_W-1:0] a_green;
    logic [SAMPLE_W-1:0] a_blue;
    logic [SAMPLE_W-1:0] b_red;
    logic [SAMPLE_W-1:0] b_green;
    logic [SAMPLE_W-1:0] b_blue;
    logic                last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               sizes_differed;
  } result_t;

  typedef struct packed {
    logic bump;
    logic clear;
    logic shift;
    logic acc_clear;
    logic div_init;
    logic div_step;
    logic div_first;
    logic load_out;
    logic out_differ;
  } cmd_t;

  typedef struct packed {
    logic differ;
    logic out_free;
  } status_t;

  function automatic logic [BIN_BITS-1:0] bin_of(input logic [SAMPLE_W-1:0] sample);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(sample) * PROD_W'(BINS);
    return BIN_BITS'(prod >> SAMPLE_W);
  endfunction

endpackage

/* rtl/core/chld_ctrl.sv */
module chld_ctrl
  import chld_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    pixel_valid,
  input  logic    pixel_last,
  output logic    pixel_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_INIT  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]         state, state_next;
  logic [SWEEP_W-1:0] sweep_cnt, sweep_cnt_next;
  logic [STEP_W-1:0]  step, step_next;
  logic               res_differ, res_differ_next;
  logic               accept;

  assign pixel_ready = (state == S_IDLE);
  assign accept      = pixel_valid && pixel_ready;

  always_comb begin
    state_next      = state;
    sweep_cnt_next  = sweep_cnt;
    step_next       = step;
    res_differ_next = res_differ;
    cmd             = '0;
    cmd.out_differ  = res_differ;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.bump = !status.differ;
          if (pixel_last) begin
            res_differ_next = status.differ;
            if (status.differ) begin
              cmd.clear  = 1'b1;
              state_next = S_OUT;
            end else begin
              cmd.acc_clear  = 1'b1;
              sweep_cnt_next = '0;
              state_next     = S_SWEEP;
            end
          end
        end
      end
      S_SWEEP: begin
        cmd.shift      = 1'b1;
        sweep_cnt_next = sweep_cnt + 1'b1;
        if (sweep_cnt == SWEEP_W'(ENTRIES - 1)) begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.div_init = 1'b1;
        step_next    = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (step == '0);
        step_next     = step + 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      sweep_cnt  <= '0;
      step       <= '0;
      res_differ <= 1'b0;
    end else begin
      state      <= state_next;
      sweep_cnt  <= sweep_cnt_next;
      step       <= step_next;
      res_differ <= res_differ_next;
    end
  end

endmodule

/* rtl/core/chld_bins.sv */
module chld_bins
  import chld_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  pixel_t pixel,
  input  cmd_t   cmd,
  output diff_t  head
);

  logic [CHANNELS-1:0][BIN_BITS-1:0] bin_a;
  logic [CHANNELS-1:0][BIN_BITS-1:0] bin_b;
  diff_t                             cnt [ENTRIES];

  assign bin_a[0] = bin_of(pixel.a_red);
  assign bin_a[1] = bin_of(pixel.a_green);
  assign bin_a[2] = bin_of(pixel.a_blue);
  assign bin_b[0] = bin_of(pixel.b_red);
  assign bin_b[1] = bin_of(pixel.b_green);
  assign bin_b[2] = bin_of(pixel.b_blue);

  assign head = cnt[0];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cnt
    localparam int C = i / BINS;
    localparam int J = i % BINS;
    diff_t upper;
    diff_t cnt_next;
    logic  hit_a;
    logic  hit_b;

    // sweep moves every counter one place toward the head and fills with zero
    if (i == ENTRIES - 1) begin : g_tail
      assign upper = '0;
    end else begin : g_mid
      assign upper = cnt[i+1];
    end

    assign hit_a = cmd.bump && (bin_a[C] == BIN_BITS'(J));
    assign hit_b = cmd.bump && (bin_b[C] == BIN_BITS'(J));

    always_comb begin
      cnt_next = cnt[i];
      priority if (cmd.clear) begin
        cnt_next = '0;
      end else if (cmd.shift) begin
        cnt_next = upper;
      end else if (hit_a && hit_b) begin
        // increment saturates first, then the decrement applies
        if (cnt[i] == DIFF_MAX) begin
          cnt_next = DIFF_MAX - diff_t'(1);
        end
      end else if (hit_a) begin
        if (cnt[i] != DIFF_MAX) begin
          cnt_next = cnt[i] + diff_t'(1);
        end
      end else if (hit_b) begin
        if (cnt[i] != DIFF_MIN) begin
          cnt_next = cnt[i] - diff_t'(1);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cnt[i] <= '0;
      end else begin
        cnt[i] <= cnt_next;
      end
    end
  end

endmodule

/* rtl/core/chld_arith.sv */
module chld_arith
  import chld_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]       cfg_data,
  input  diff_t                  head,
  input  cmd_t                   cmd,
  output status_t                status,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result
);

  logic [REG_W-1:0]     a_width, a_height, b_width, b_height;
  logic [AREA_W-1:0]    area;
  logic [DIVISOR_W-1:0] divisor;
  logic [DIFF_W-1:0]    mag;
  logic [SUM_W-1:0]     sum;
  logic [SUM_W-1:0]     rem;
  logic [SUM_W-1:0]     trial;
  logic                 ge;
  logic [SCORE_W-1:0]   quo;
  logic                 sat;
  logic                 zero;
  logic [SCORE_W-1:0]   score;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_width  <= REG_W'(1);
      a_height <= REG_W'(1);
      b_width  <= REG_W'(1);
      b_height <= REG_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_A_WIDTH:  a_width  <= cfg_data;
        REG_A_HEIGHT: a_height <= cfg_data;
        REG_B_WIDTH:  b_width  <= cfg_data;
        REG_B_HEIGHT: b_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign status.differ   = (a_width != b_width) || (a_height != b_height);
  assign status.out_free = !result_valid || result_ready;

  // divisor is six times the area
  always_ff @(posedge clk) begin
    area    <= AREA_W'(a_width) * AREA_W'(a_height);
    divisor <= (DIVISOR_W'(area) << 2) + (DIVISOR_W'(area) << 1);
  end

  assign mag = head[DIFF_W-1] ? DIFF_W'($unsigned(-head)) : DIFF_W'($unsigned(head));

  always_ff @(posedge clk) begin
    if (cmd.acc_clear) begin
      sum <= '0;
    end else if (cmd.shift) begin
      sum <= sum + SUM_W'(mag);
    end
  end

  // restoring division, one quotient bit a step
  assign trial = cmd.div_first ? rem : (rem << 1);
  assign ge    = (trial >= SUM_W'(divisor));

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem  <= sum;
      quo  <= '0;
      sat  <= ({1'b0, sum} >= ((SUM_W+1)'(divisor) << 1));
      zero <= (divisor == '0);
    end else if (cmd.div_step) begin
      rem <= ge ? (trial - SUM_W'(divisor)) : trial;
      quo <= {quo[SCORE_W-2:0], ge};
    end
  end

  always_comb begin
    priority if (zero) begin
      score = '0;
    end else if (sat || (quo > SCORE_ONE)) begin
      score = SCORE_ONE;
    end else begin
      score = quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (cmd.out_differ) begin
        result.score          <= SCORE_ONE;
        result.sizes_differed <= 1'b1;
      end else begin
        result.score          <= score;
        result.sizes_differed <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/color_histogram_l1_distance.sv */
// throughput: one pixel pair a cycle while pixel_ready is high
// last pair: a sweep over all 48 counters, a setup step and 17 divide steps, then the result
//   beat is loaded once the output is free; when the sizes differ it is loaded directly
// pixel_ready stays low from the last pair until the result is loaded
// reset (rst, synchronous, active high): counters cleared at once, size registers to 1
module color_histogram_l1_distance
  import chld_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pixel_valid,
  output logic                   pixel_ready,
  input  pixel_t                 pixel,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]       cfg_data
);

  cmd_t    cmd;
  status_t status;
  diff_t   head;

  chld_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_last  (pixel.last_pixel),
    .pixel_ready (pixel_ready),
    .status      (status),
    .cmd         (cmd)
  );

  chld_bins u_bins (
    .clk   (clk),
    .rst   (rst),
    .pixel (pixel),
    .cmd   (cmd),
    .head  (head)
  );

  chld_arith u_arith (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .head         (head),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

/* rtl/core/chld_check.sv */
module chld_check
  import chld_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    pixel_valid,
  input logic    pixel_ready,
  input pixel_t  pixel,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  // stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // no pixel taken in the cycle after the last pair
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_ready && pixel.last_pixel |=> !pixel_ready)
    else $error("pixel accepted right after the last pair");

  a_score_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.score <= SCORE_ONE))
    else $error("score above one");

  a_differ_one: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.sizes_differed |-> (result.score == SCORE_ONE))
    else $error("size mismatch without full score");

endmodule

bind color_histogram_l1_distance chld_check u_chld_check (.*);
